@@ rtl/rls_pkg.sv @@
package rls_pkg;

  // Width of one multiplier digit; the multiplier retires this many bits of
  // its second operand per cycle.
  localparam int DIGIT_BITS = 4;

  // The variance result is always Q48.16 sized: 64 bits.
  localparam int VAR_BITS = 64;

  // Counter width of the divider; it runs up to VAR_BITS steps.
  localparam int DIV_ITER_BITS = $clog2(VAR_BITS + 1);

  // Handshake status that each arithmetic unit reports to the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } unit_status_t;

endpackage

@@ rtl/running_latency_statistics_top.sv @@
// Running latency statistics. Each request on the input channel carries one
// measured interval in timer ticks; each one produces exactly one request on
// the output channel holding the sample count, the running mean (Q24.16), the
// running sample variance (Q48.16), the maximum, the minimum and a flag that
// tells whether the count had already saturated.
// Both channels use valid/ready. One sample is processed at a time. The first
// sample, and any sample after the count has saturated, goes from acceptance
// straight to the commit state, with no arithmetic.
// Any other sample runs through a sequencer that
// drives a radix-16 digit-serial multiplier (one 4-bit digit of the second
// operand per cycle, seven products) and a one-bit-per-cycle restoring divider
// (MEAN_BITS steps for the mean, 64 steps for the variance). A product ends
// early when its second operand has leading zero digits; the divider steps
// dominate the processing time.
// The statistics registers themselves drive the output ports. While a result
// waits for the receiver, the next sample is accepted and fully computed; it
// is only committed once the waiting result has been taken, so a stalled
// receiver holds back at most one finished computation.
// Reset clears the count, mean, variance and maximum and sets the minimum to
// all ones; no result is pending after reset.
module running_latency_statistics_top
  import rls_pkg::*;
#(
  parameter int SAMPLE_BITS = 24,
  parameter int FRAC_BITS   = 16,
  parameter int COUNT_BITS  = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [SAMPLE_BITS-1:0]         sample_ticks_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [COUNT_BITS-1:0]          sample_count_o,
  output logic [SAMPLE_BITS+FRAC_BITS-1:0] mean_value_o,
  output logic [VAR_BITS-1:0]            variance_value_o,
  output logic [SAMPLE_BITS-1:0]         max_ticks_o,
  output logic [SAMPLE_BITS-1:0]         min_ticks_o,
  output logic                           count_saturated_o
);

  localparam int MEAN_BITS  = SAMPLE_BITS + FRAC_BITS;
  localparam int VTERM_BITS = VAR_BITS + COUNT_BITS + FRAC_BITS;
  localparam int MTERM_BITS = 2 * MEAN_BITS + COUNT_BITS;
  // Wide enough that every term of the variance numerator is exact.
  localparam int WIDE_BITS  = ((VTERM_BITS > MTERM_BITS) ? VTERM_BITS : MTERM_BITS) + 2;
  localparam int MUL_B_BITS = (MEAN_BITS > COUNT_BITS) ? MEAN_BITS : COUNT_BITS;
  localparam int DIV_BITS   = COUNT_BITS + FRAC_BITS;

  // One-hot sequencer states. Each multiply state runs one product in the
  // shared multiplier; the two divide states use the shared divider.
  typedef enum logic [12:0] {
    ST_IDLE     = 13'b0000000000001,
    ST_MEAN_MUL = 13'b0000000000010,
    ST_MEAN_DIV = 13'b0000000000100,
    ST_SQ_OLD   = 13'b0000000001000,
    ST_POS_A    = 13'b0000000010000,
    ST_POS_B    = 13'b0000000100000,
    ST_POS_C    = 13'b0000001000000,
    ST_SQ_NEW   = 13'b0000010000000,
    ST_NEG      = 13'b0000100000000,
    ST_CHECK    = 13'b0001000000000,
    ST_SAT      = 13'b0010000000000,
    ST_VAR_DIV  = 13'b0100000000000,
    ST_DONE     = 13'b1000000000000
  } st_e;

  st_e st_q, st_d;

  logic mul_start_q, mul_start_d;
  logic div_start_q, div_start_d;

  // Statistics; these also form the output register.
  logic [COUNT_BITS-1:0]  count_q, count_d;
  logic [MEAN_BITS-1:0]   mean_q, mean_d;
  logic [VAR_BITS-1:0]    var_q, var_d;
  logic [SAMPLE_BITS-1:0] max_q, max_d;
  logic [SAMPLE_BITS-1:0] min_q, min_d;
  logic                   sat_q, sat_d;
  logic                   out_valid_q, out_valid_d;

  // Working registers of the sample in flight.
  logic [SAMPLE_BITS-1:0] x_q, x_d;
  logic [MEAN_BITS-1:0]   mnew_q, mnew_d;
  logic [WIDE_BITS-1:0]   pos_q, pos_d;
  logic [VAR_BITS-1:0]    var_new_q, var_new_d;

  logic                   count_zero;
  logic                   count_full;
  logic [COUNT_BITS-1:0]  n_val;
  logic [COUNT_BITS-1:0]  n_minus2;
  logic [DIV_BITS-1:0]    var_div;

  logic [WIDE_BITS-1:0]   mul_a;
  logic [MUL_B_BITS-1:0]  mul_b;
  logic [WIDE_BITS-1:0]   mul_acc;
  logic [WIDE_BITS-1:0]   prod;
  unit_status_t           mul_st;

  logic [DIV_BITS-1:0]      div_rem;
  logic [VAR_BITS-1:0]      div_num;
  logic [DIV_BITS-1:0]      div_den;
  logic [DIV_ITER_BITS-1:0] div_iters;
  logic [VAR_BITS-1:0]      quot;
  unit_status_t             div_st;

  // The sample being processed is number n = count + 1. The mean divides by
  // n; the variance divides by (n - 1) scaled to the fraction format.
  assign count_zero = (count_q == '0);
  assign count_full = &count_q;
  assign n_val      = count_q + 1'b1;
  assign n_minus2   = count_q - 1'b1;
  assign var_div    = DIV_BITS'(count_q) << FRAC_BITS;

  // Multiplier operands. The variance numerator is built up in the
  // accumulator: (n-1)*mold^2, then + x^2 scaled, then + (n-2)*var scaled.
  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    mul_acc = '0;
    case (st_q)
      ST_MEAN_MUL: begin
        mul_a   = WIDE_BITS'(mean_q);
        mul_b   = MUL_B_BITS'(count_q);
        mul_acc = WIDE_BITS'(x_q) << FRAC_BITS;
      end
      ST_SQ_OLD: begin
        mul_a = WIDE_BITS'(mean_q);
        mul_b = MUL_B_BITS'(mean_q);
      end
      ST_POS_A: begin
        mul_a = prod;
        mul_b = MUL_B_BITS'(count_q);
      end
      ST_POS_B: begin
        mul_a   = WIDE_BITS'(x_q) << (2 * FRAC_BITS);
        mul_b   = MUL_B_BITS'(x_q);
        mul_acc = prod;
      end
      ST_POS_C: begin
        mul_a   = WIDE_BITS'(var_q) << FRAC_BITS;
        mul_b   = MUL_B_BITS'(n_minus2);
        mul_acc = prod;
      end
      ST_SQ_NEW: begin
        mul_a = WIDE_BITS'(mnew_q);
        mul_b = MUL_B_BITS'(mnew_q);
      end
      ST_NEG: begin
        mul_a = prod;
        mul_b = MUL_B_BITS'(n_val);
      end
      default: begin
        mul_a   = '0;
        mul_b   = '0;
        mul_acc = '0;
      end
    endcase
  end

  // Divider operands. The quotient of the mean is known to fit MEAN_BITS,
  // so the upper part of the numerator is already the starting remainder.
  // For the variance, a starting remainder not below the divisor means the
  // quotient needs more than 64 bits; that case is caught before.
  always_comb begin
    if (st_q == ST_MEAN_DIV) begin
      div_rem   = DIV_BITS'(prod >> MEAN_BITS);
      div_num   = VAR_BITS'(prod[MEAN_BITS-1:0]) << (VAR_BITS - MEAN_BITS);
      div_den   = DIV_BITS'(n_val);
      div_iters = DIV_ITER_BITS'(MEAN_BITS);
    end else begin
      div_rem   = DIV_BITS'(pos_q >> VAR_BITS);
      div_num   = pos_q[VAR_BITS-1:0];
      div_den   = var_div;
      div_iters = DIV_ITER_BITS'(VAR_BITS);
    end
  end

  rls_mul #(
    .A_BITS(WIDE_BITS),
    .B_BITS(MUL_B_BITS)
  ) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start_q),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .acc_i   (mul_acc),
    .status_o(mul_st),
    .prod_o  (prod)
  );

  rls_div #(
    .DIV_BITS(DIV_BITS)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start_q),
    .rem_i   (div_rem),
    .num_i   (div_num),
    .div_i   (div_den),
    .iters_i (div_iters),
    .status_o(div_st),
    .quot_o  (quot)
  );

  // Sequencer and commit of the statistics.
  always_comb begin
    st_d        = st_q;
    mul_start_d = 1'b0;
    div_start_d = 1'b0;
    x_d         = x_q;
    mnew_d      = mnew_q;
    pos_d       = pos_q;
    var_new_d   = var_new_q;
    count_d     = count_q;
    mean_d      = mean_q;
    var_d       = var_q;
    max_d       = max_q;
    min_d       = min_q;
    sat_d       = sat_q;
    out_valid_d = out_valid_q && !out_ready_i;

    case (st_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          x_d = sample_ticks_i;
          // The first sample and samples after saturation need no arithmetic.
          if (count_zero || count_full) begin
            st_d = ST_DONE;
          end else begin
            st_d        = ST_MEAN_MUL;
            mul_start_d = 1'b1;
          end
        end
      end
      ST_MEAN_MUL: begin
        if (mul_st.done) begin
          st_d        = ST_MEAN_DIV;
          div_start_d = 1'b1;
        end
      end
      ST_MEAN_DIV: begin
        if (div_st.done) begin
          mnew_d      = quot[MEAN_BITS-1:0];
          st_d        = ST_SQ_OLD;
          mul_start_d = 1'b1;
        end
      end
      ST_SQ_OLD: begin
        if (mul_st.done) begin
          st_d        = ST_POS_A;
          mul_start_d = 1'b1;
        end
      end
      ST_POS_A: begin
        if (mul_st.done) begin
          st_d        = ST_POS_B;
          mul_start_d = 1'b1;
        end
      end
      ST_POS_B: begin
        if (mul_st.done) begin
          st_d        = ST_POS_C;
          mul_start_d = 1'b1;
        end
      end
      ST_POS_C: begin
        if (mul_st.done) begin
          pos_d       = prod;
          st_d        = ST_SQ_NEW;
          mul_start_d = 1'b1;
        end
      end
      ST_SQ_NEW: begin
        if (mul_st.done) begin
          st_d        = ST_NEG;
          mul_start_d = 1'b1;
        end
      end
      ST_NEG: begin
        if (mul_st.done) begin
          st_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        // A numerator that is zero or negative clamps the variance to zero.
        if (pos_q <= prod) begin
          var_new_d = '0;
          st_d      = ST_DONE;
        end else begin
          pos_d = pos_q - prod;
          st_d  = ST_SAT;
        end
      end
      ST_SAT: begin
        if ((pos_q >> VAR_BITS) >= WIDE_BITS'(var_div)) begin
          var_new_d = '1;
          st_d      = ST_DONE;
        end else begin
          st_d        = ST_VAR_DIV;
          div_start_d = 1'b1;
        end
      end
      ST_VAR_DIV: begin
        if (div_st.done) begin
          var_new_d = quot;
          st_d      = ST_DONE;
        end
      end
      ST_DONE: begin
        // Commit only once the previous result has left the output.
        if (!out_valid_q || out_ready_i) begin
          st_d        = ST_IDLE;
          out_valid_d = 1'b1;
          if (count_zero) begin
            count_d = COUNT_BITS'(1);
            mean_d  = MEAN_BITS'(x_q) << FRAC_BITS;
            var_d   = '0;
            max_d   = x_q;
            min_d   = x_q;
            sat_d   = 1'b0;
          end else begin
            max_d = (x_q > max_q) ? x_q : max_q;
            min_d = (x_q < min_q) ? x_q : min_q;
            if (count_full) begin
              sat_d = 1'b1;
            end else begin
              count_d = n_val;
              mean_d  = mnew_q;
              var_d   = var_new_q;
              sat_d   = 1'b0;
            end
          end
        end
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      mul_start_q <= 1'b0;
      div_start_q <= 1'b0;
      count_q     <= '0;
      mean_q      <= '0;
      var_q       <= '0;
      max_q       <= '0;
      min_q       <= '1;
      sat_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      mul_start_q <= mul_start_d;
      div_start_q <= div_start_d;
      count_q     <= count_d;
      mean_q      <= mean_d;
      var_q       <= var_d;
      max_q       <= max_d;
      min_q       <= min_d;
      sat_q       <= sat_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q       <= x_d;
    mnew_q    <= mnew_d;
    pos_q     <= pos_d;
    var_new_q <= var_new_d;
  end

  assign in_ready_o        = (st_q == ST_IDLE);
  assign out_valid_o       = out_valid_q;
  assign sample_count_o    = count_q;
  assign mean_value_o      = mean_q;
  assign variance_value_o  = var_q;
  assign max_ticks_o       = max_q;
  assign min_ticks_o       = min_q;
  assign count_saturated_o = sat_q;

  // The sequencer never runs both arithmetic units at once.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mul_st.busy && div_st.busy))
    else $error("multiplier and divider busy together");

  // A result flagged as saturated always carries the full count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && sat_q) |-> count_full)
    else $error("saturation flag without a full count");

  // Once any sample is in, the minimum never exceeds the maximum.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !count_zero |-> (min_q <= max_q))
    else $error("minimum above maximum");

  // A saturated count stays saturated.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_full |=> count_full)
    else $error("saturated count changed");

  // After a single sample the variance is zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == COUNT_BITS'(1)) |-> (var_q == '0))
    else $error("nonzero variance after one sample");

endmodule

@@ rtl/rls_mul.sv @@
module rls_mul
  import rls_pkg::*;
#(
  parameter int A_BITS = 114,
  parameter int B_BITS = 40
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [A_BITS-1:0]   a_i,
  input  logic [B_BITS-1:0]   b_i,
  input  logic [A_BITS-1:0]   acc_i,
  output unit_status_t        status_o,
  output logic [A_BITS-1:0]   prod_o
);

  logic [A_BITS-1:0]            a_q, a_d;
  logic [B_BITS-1:0]            b_q, b_d;
  logic [A_BITS-1:0]            acc_q, acc_d;
  logic                         busy_q, busy_d;
  logic                         done_q, done_d;
  logic [A_BITS+DIGIT_BITS-1:0] part;

  // One partial product per cycle: the wide operand times one digit.
  assign part = a_q * b_q[DIGIT_BITS-1:0];

  always_comb begin
    a_d    = a_q;
    b_d    = b_q;
    acc_d  = acc_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      a_d    = a_i;
      b_d    = b_i;
      acc_d  = acc_i;
      busy_d = 1'b1;
    end else if (busy_q) begin
      // The product is complete as soon as no nonzero digit remains.
      if (b_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        acc_d = acc_q + part[A_BITS-1:0];
        a_d   = a_q << DIGIT_BITS;
        b_d   = b_q >> DIGIT_BITS;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    b_q   <= b_d;
    acc_q <= acc_d;
  end

  assign status_o.busy = busy_q;
  assign status_o.done = done_q;
  assign prod_o        = acc_q;

endmodule

@@ rtl/rls_div.sv @@
module rls_div
  import rls_pkg::*;
#(
  parameter int DIV_BITS = 48
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [DIV_BITS-1:0]      rem_i,
  input  logic [VAR_BITS-1:0]      num_i,
  input  logic [DIV_BITS-1:0]      div_i,
  input  logic [DIV_ITER_BITS-1:0] iters_i,
  output unit_status_t             status_o,
  output logic [VAR_BITS-1:0]      quot_o
);

  logic [DIV_BITS-1:0]      rem_q, rem_d;
  logic [VAR_BITS-1:0]      num_q, num_d;
  logic [VAR_BITS-1:0]      quot_q, quot_d;
  logic [DIV_BITS-1:0]      div_q, div_d;
  logic [DIV_ITER_BITS-1:0] cnt_q, cnt_d;
  logic                     busy_q, busy_d;
  logic                     done_q, done_d;
  logic [DIV_BITS:0]        trial;
  logic [DIV_BITS:0]        diff;
  logic                     fits;

  // Restoring division, one quotient bit per cycle. The partial remainder
  // always stays below the divisor, so it fits in DIV_BITS bits.
  assign trial = {rem_q, num_q[VAR_BITS-1]};
  assign diff  = trial - {1'b0, div_q};
  assign fits  = trial >= {1'b0, div_q};

  always_comb begin
    rem_d  = rem_q;
    num_d  = num_q;
    quot_d = quot_q;
    div_d  = div_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = rem_i;
      num_d  = num_i;
      quot_d = '0;
      div_d  = div_i;
      cnt_d  = iters_i;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        rem_d  = fits ? diff[DIV_BITS-1:0] : trial[DIV_BITS-1:0];
        num_d  = num_q << 1;
        quot_d = {quot_q[VAR_BITS-2:0], fits};
        cnt_d  = cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    num_q  <= num_d;
    quot_q <= quot_d;
    div_q  <= div_d;
  end

  assign status_o.busy = busy_q;
  assign status_o.done = done_q;
  assign quot_o        = quot_q;

endmodule

@@ test/running_latency_statistics_top_tb.sv @@
`timescale 1ns / 1ps

// Self-checking bench for the running latency statistics block. Samples go in
// through a valid/ready driver that works in bursts with random gaps; the
// statistics come back through a monitor whose ready line stalls on a pattern
// of its own. Every accepted sample is run through a bit-exact predictor kept
// here, and the result it computes is queued until the block's result arrives.
module running_latency_statistics_top_tb;
  import rls_pkg::*;

  localparam int SAMPLE_BITS = 24;
  localparam int FRAC_BITS   = 16;
  localparam int COUNT_BITS  = 32;
  localparam int MEAN_BITS   = SAMPLE_BITS + FRAC_BITS;
  localparam int RANDOM_SAMPLES = 1630;
  // One long receiver hold-off, long enough to fill the block and stall its input.
  localparam int HOLD_OFF_CYCLES = 1500;
  localparam int HOLD_OFF_AFTER  = 150;
  // Idle margin after the last expected result, beyond the block's slowest sample.
  localparam int DRAIN_CYCLES = 400;
  localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = '1;

  typedef logic [127:0] wide_t;

  typedef struct packed {
    logic [COUNT_BITS-1:0]  count;
    logic [MEAN_BITS-1:0]   mean;
    logic [VAR_BITS-1:0]    variance;
    logic [SAMPLE_BITS-1:0] max_ticks;
    logic [SAMPLE_BITS-1:0] min_ticks;
    logic                   saturated;
  } stats_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   in_valid_i = 1'b0;
  logic                   in_ready_o;
  logic [SAMPLE_BITS-1:0] sample_ticks_i = '0;
  logic                   out_valid_o;
  logic                   out_ready_i = 1'b0;
  logic [COUNT_BITS-1:0]  sample_count_o;
  logic [MEAN_BITS-1:0]   mean_value_o;
  logic [VAR_BITS-1:0]    variance_value_o;
  logic [SAMPLE_BITS-1:0] max_ticks_o;
  logic [SAMPLE_BITS-1:0] min_ticks_o;
  logic                   count_saturated_o;

  running_latency_statistics_top #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .FRAC_BITS  (FRAC_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .sample_ticks_i   (sample_ticks_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .sample_count_o   (sample_count_o),
    .mean_value_o     (mean_value_o),
    .variance_value_o (variance_value_o),
    .max_ticks_o      (max_ticks_o),
    .min_ticks_o      (min_ticks_o),
    .count_saturated_o(count_saturated_o)
  );

  always #1 clk_i = ~clk_i;

  // Samples still to be offered, and the statistics the block owes us, oldest first.
  logic [SAMPLE_BITS-1:0] pending_samples[$];
  stats_t                 stats_due[$];

  // Appends one sample to the end of the stimulus queue.
  task automatic queue_sample(input logic [SAMPLE_BITS-1:0] s);
    pending_samples.insert(pending_samples.size(), s);
  endtask

  // Predicted statistics registers, cleared the same way the block's reset does.
  logic [COUNT_BITS-1:0]  count_q = '0;
  logic [MEAN_BITS-1:0]   mean_q = '0;
  logic [VAR_BITS-1:0]    var_q = '0;
  logic [SAMPLE_BITS-1:0] max_q = '0;
  logic [SAMPLE_BITS-1:0] min_q = '1;

  int samples_taken = 0;
  int results_seen = 0;
  int error_cnt = 0;
  int clamp_cnt = 0;
  int input_stall_cycles = 0;
  logic [VAR_BITS-1:0] peak_variance = '0;

  // Folds one sample into the predicted statistics and returns the result the
  // block must report for it. All products are formed exactly in 128 bits.
  function automatic stats_t update_stats(input logic [SAMPLE_BITS-1:0] x);
    wide_t xw, mo, vo, n, num, pos, neg, quo;
    logic [MEAN_BITS-1:0] new_mean;
    stats_t r;
    r.saturated = 1'b0;
    if (count_q == '0) begin
      // The first sample defines the mean, both extremes and a zero variance.
      count_q = COUNT_BITS'(1);
      mean_q = MEAN_BITS'(x) << FRAC_BITS;
      var_q = '0;
      max_q = x;
      min_q = x;
    end else begin
      if (x > max_q) max_q = x;
      if (x < min_q) min_q = x;
      if (count_q == '1) begin
        // A saturated count freezes the mean and the variance.
        r.saturated = 1'b1;
      end else begin
        xw = wide_t'(x);
        mo = wide_t'(mean_q);
        vo = wide_t'(var_q);
        n = wide_t'(count_q) + 1;
        num = (xw << FRAC_BITS) + mo * (n - 1);
        new_mean = MEAN_BITS'(num / n);
        pos = ((vo * (n - 2)) << FRAC_BITS) + ((xw * xw) << (2 * FRAC_BITS))
              + mo * mo * (n - 1);
        neg = wide_t'(new_mean) * wide_t'(new_mean) * n;
        if (pos <= neg) begin
          // Truncation in the mean can push the numerator to zero or below.
          var_q = '0;
          clamp_cnt++;
        end else begin
          quo = (pos - neg) / ((n - 1) << FRAC_BITS);
          var_q = (quo[127:VAR_BITS] != '0) ? '1 : quo[VAR_BITS-1:0];
        end
        mean_q = new_mean;
        count_q = COUNT_BITS'(n);
      end
    end
    if (var_q > peak_variance) peak_variance = var_q;
    r.count = count_q;
    r.mean = mean_q;
    r.variance = var_q;
    r.max_ticks = max_q;
    r.min_ticks = min_q;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      error_cnt++;
      if (error_cnt <= 10)
        $display("tb: result %0d %s mismatch: expected 0x%0h, got 0x%0h",
                 results_seen, name, want, got);
    end
  endtask

  // Driver. Requests are offered in bursts; a gap only starts once the current
  // request has been accepted, so valid and the payload hold until then.
  int burst_left = 1;
  int gap_left = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_ready_o) input_stall_cycles++;
      if (in_valid_i && in_ready_o) begin
        stats_due.insert(stats_due.size(), update_stats(sample_ticks_i));
        samples_taken++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (pending_samples.size() != 0) begin
          in_valid_i <= 1'b1;
          sample_ticks_i <= pending_samples.pop_front();
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            // Short, medium and long gaps, so that they land on every step of
            // the block's multiply and divide sequence.
            case ($urandom_range(0, 3))
              0: gap_left = 0;
              1: gap_left = $urandom_range(1, 8);
              2: gap_left = $urandom_range(9, 60);
              default: gap_left = $urandom_range(61, 250);
            endcase
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver. Ready follows a stall mode that is redrawn at random; once
  // in the run it is held low for a long stretch while the driver keeps offering.
  int stall_mode = 0;
  int mode_left = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else if (!hold_done && results_seen >= HOLD_OFF_AFTER) begin
      hold_done = 1'b1;
      hold_left = HOLD_OFF_CYCLES;
      out_ready_i <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 400);
      end
      mode_left--;
      case (stall_mode)
        0: out_ready_i <= 1'b1;
        1: out_ready_i <= 1'($urandom_range(0, 1));
        2: out_ready_i <= ($urandom_range(0, 9) != 0);
        default: out_ready_i <= ($urandom_range(0, 19) == 0);
      endcase
    end
  end

  // Monitor. Each accepted result is checked against the oldest prediction.
  always @(posedge clk_i) begin
    stats_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (stats_due.size() == 0) begin
        error_cnt++;
        if (error_cnt <= 10)
          $display("tb: result %0d arrived with no sample outstanding", results_seen);
      end else begin
        want = stats_due.pop_front();
        check_field("sample_count", 64'(want.count), 64'(sample_count_o));
        check_field("mean_value", 64'(want.mean), 64'(mean_value_o));
        check_field("variance_value", want.variance, variance_value_o);
        check_field("max_ticks", 64'(want.max_ticks), 64'(max_ticks_o));
        check_field("min_ticks", 64'(want.min_ticks), 64'(min_ticks_o));
        check_field("count_saturated", 64'(want.saturated), 64'(count_saturated_o));
      end
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    logic [SAMPLE_BITS-1:0] anchor;
    logic [SAMPLE_BITS-1:0] directed[$];

    // Directed part. Three equal opening samples exercise the first-sample
    // path and a variance numerator that cancels to exactly zero; the rest
    // walk the extremes and alternating bit patterns through max and min.
    directed = '{24'd7, 24'd7, 24'd7, 24'd8, 24'd6, SAMPLE_MAX, 24'd0,
                 24'h800000, 24'h7FFFFF, 24'hAAAAAA, 24'h555555, 24'd1,
                 SAMPLE_MAX - 1, 24'd0, SAMPLE_MAX, SAMPLE_MAX, 24'd0, 24'h000100,
                 24'h00FFFF, 24'hFF0000};
    foreach (directed[i]) queue_sample(directed[i]);

    // Random part: full-range values, small values, extremes, clusters around
    // a drifting anchor, and single-bit values.
    anchor = SAMPLE_BITS'($urandom);
    repeat (RANDOM_SAMPLES) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: queue_sample(SAMPLE_BITS'($urandom_range(0, SAMPLE_MAX)));
        4, 5: queue_sample(SAMPLE_BITS'($urandom_range(0, 255)));
        6: begin
          case ($urandom_range(0, 3))
            0: queue_sample('0);
            1: queue_sample(SAMPLE_BITS'(1));
            2: queue_sample(SAMPLE_MAX - 1);
            default: queue_sample(SAMPLE_MAX);
          endcase
        end
        7, 8: begin
          if ($urandom_range(0, 15) == 0) anchor = SAMPLE_BITS'($urandom);
          queue_sample(anchor + SAMPLE_BITS'($urandom_range(0, 3)));
        end
        default: queue_sample(SAMPLE_BITS'(1) << $urandom_range(0, 23));
      endcase
    end

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (pending_samples.size() != 0 || in_valid_i) @(posedge clk_i);
    while (stats_due.size() != 0) @(posedge clk_i);
    // Give a misbehaving block the chance to send a result nobody asked for.
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("tb: %0d samples in, %0d results checked, %0d cycles of input backpressure",
             samples_taken, results_seen, input_stall_cycles);
    $display("tb: final count %0d, min %0d, max %0d, %0d zero-clamped variances, peak 0x%0h",
             count_q, min_q, max_q, clamp_cnt, peak_variance);
    if (error_cnt == 0 && stats_due.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: %0d errors", error_cnt);
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog: well beyond the slowest legal run, including the long hold-off.
  initial begin
    #20_000_000;
    $display("tb: timeout with %0d results still outstanding", stats_due.size());
    $display("tb: failure");
    $finish;
  end

endmodule
